// ----- src/cau_pkg.sv -----
// Shared constants, types and helpers of the complex arithmetic unit.
package cau_pkg;
	localparam int DW   = 16;          // operand and result width
	localparam int FB   = 8;           // fraction bits
	localparam int PW   = 2 * DW;      // product width
	localparam int SW   = PW + 1;      // width of a sum of two products
	localparam int QW   = DW;          // quotient bits resolved by the divider
	localparam int RW   = PW + QW;     // divider remainder width
	localparam int NSTG = QW;          // divider stages, one quotient bit each

	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd1;
	localparam logic [2:0] FN_MUL = 3'd2;
	localparam logic [2:0] FN_DIV = 3'd3;
	localparam logic [2:0] FN_CMP = 3'd4;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

	typedef struct packed {
		logic signed [DW-1:0] val;
		logic                 sat;
	} clip_t;

	// Everything that rides alongside the divider lanes.
	typedef struct packed {
		logic [2:0]           fn;
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		logic                 sat;
		logic                 eq;
		logic                 dz;
		logic                 neg_re;
		logic                 neg_im;
		logic                 ovf_re;
		logic                 ovf_im;
	} side_t;

	// Saturate a wide signed value to the result width.
	function automatic clip_t clip(input logic signed [SW-1:0] v);
		clip_t r;
		if (v > SW'(DMAX)) begin
			r.val = DMAX;
			r.sat = 1'b1;
		end else if (v < SW'(DMIN)) begin
			r.val = DMIN;
			r.sat = 1'b1;
		end else begin
			r.val = v[DW-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction
endpackage

// ----- src/complex_arithmetic_unit_core.sv -----
// Top level of the pipelined complex arithmetic unit.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+-------------------------------
//  command | func, a_re, a_im, b_re, b_im             | beat taken when start & !busy
//  result  | res_re, res_im, is_equal, status         | beat shown for one cycle by done
//
// A beat enters every cycle; its result is registered through stages 1 to 3, the divider
// stages and the output stage. The restoring divider, which resolves one quotient bit per
// stage, gives most of this depth; all operations travel the same stages so order is kept.
// busy is never raised, and the receiver cannot stall, so nothing ever backs up.
// arst_n clears the valid bits only; the data registers are not reset.
module complex_arithmetic_unit_core
	import cau_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           func,
	input  logic signed [DW-1:0] a_re,
	input  logic signed [DW-1:0] a_im,
	input  logic signed [DW-1:0] b_re,
	input  logic signed [DW-1:0] b_im,
	output logic                 done,
	output logic signed [DW-1:0] res_re,
	output logic signed [DW-1:0] res_im,
	output logic                 is_equal,
	output logic [1:0]           status
);

	assign busy = 1'b0;

	// Stage 1: the six products, the plain sums and differences, and the compare.
	logic                   v_s1;
	logic [2:0]             fn_s1;
	logic signed [DW:0]     add_re_s1, add_im_s1, sub_re_s1, sub_im_s1;
	logic                   eq_s1;
	logic signed [PW-1:0]   ac_s1, bd_s1, ad_s1, bc_s1, cc_s1, dd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		fn_s1     <= func;
		add_re_s1 <= (DW+1)'(a_re) + (DW+1)'(b_re);
		add_im_s1 <= (DW+1)'(a_im) + (DW+1)'(b_im);
		sub_re_s1 <= (DW+1)'(a_re) - (DW+1)'(b_re);
		sub_im_s1 <= (DW+1)'(a_im) - (DW+1)'(b_im);
		eq_s1     <= (a_re == b_re) && (a_im == b_im);
		ac_s1     <= PW'(a_re) * PW'(b_re);
		bd_s1     <= PW'(a_im) * PW'(b_im);
		ad_s1     <= PW'(a_re) * PW'(b_im);
		bc_s1     <= PW'(a_im) * PW'(b_re);
		cc_s1     <= PW'(b_re) * PW'(b_re);
		dd_s1     <= PW'(b_im) * PW'(b_im);
	end

	// Stage 2: sums of products, the denominator, and saturation of add and subtract.
	logic                   v_s2;
	logic [2:0]             fn_s2;
	logic signed [DW-1:0]   as_re_s2, as_im_s2;
	logic                   as_sat_s2, eq_s2;
	logic signed [SW-1:0]   mre_s2, mim_s2, dre_s2, dim_s2;
	logic [PW-1:0]          den_s2;
	clip_t                  ar_c, ai_c, sr_c, si_c;

	always_comb begin
		ar_c = clip(SW'(add_re_s1));
		ai_c = clip(SW'(add_im_s1));
		sr_c = clip(SW'(sub_re_s1));
		si_c = clip(SW'(sub_im_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		fn_s2 <= fn_s1;
		eq_s2 <= eq_s1;
		if (fn_s1 == FN_SUB) begin
			as_re_s2  <= sr_c.val;
			as_im_s2  <= si_c.val;
			as_sat_s2 <= sr_c.sat | si_c.sat;
		end else begin
			as_re_s2  <= ar_c.val;
			as_im_s2  <= ai_c.val;
			as_sat_s2 <= ar_c.sat | ai_c.sat;
		end
		mre_s2 <= SW'(ac_s1) - SW'(bd_s1);
		mim_s2 <= SW'(ad_s1) + SW'(bc_s1);
		dre_s2 <= SW'(ac_s1) + SW'(bd_s1);
		dim_s2 <= SW'(bc_s1) - SW'(ad_s1);
		den_s2 <= PW'(cc_s1) + PW'(dd_s1);
	end

	// Stage 3: scale and saturate products, and prepare the divider operands.
	// A magnitude at or above den * 2^(QW-FB) gives a quotient that cannot fit.
	logic                   v_s3;
	side_t                  side_s3;
	logic [RW-1:0]          rre_s3, rim_s3;
	logic [PW-1:0]          den_s3;
	clip_t                  mr_c, mi_c;
	logic                   nre, nim;
	logic [PW-1:0]          mag_re, mag_im;
	logic [RW-1:0]          nre_w, nim_w, dlim;
	side_t                  side_n;

	always_comb begin
		mr_c   = clip(mre_s2 >>> FB);
		mi_c   = clip(mim_s2 >>> FB);
		nre    = dre_s2[SW-1];
		nim    = dim_s2[SW-1];
		mag_re = nre ? PW'(-dre_s2) : PW'(dre_s2);
		mag_im = nim ? PW'(-dim_s2) : PW'(dim_s2);
		nre_w  = RW'(mag_re) << FB;
		nim_w  = RW'(mag_im) << FB;
		dlim   = RW'(den_s2) << QW;

		side_n        = '0;
		side_n.fn     = fn_s2;
		side_n.neg_re = nre;
		side_n.neg_im = nim;
		side_n.ovf_re = nre_w >= dlim;
		side_n.ovf_im = nim_w >= dlim;
		side_n.dz     = den_s2 == '0;
		unique case (fn_s2)
			FN_ADD, FN_SUB: begin
				side_n.re  = as_re_s2;
				side_n.im  = as_im_s2;
				side_n.sat = as_sat_s2;
			end
			FN_MUL: begin
				side_n.re  = mr_c.val;
				side_n.im  = mi_c.val;
				side_n.sat = mr_c.sat | mi_c.sat;
			end
			FN_CMP: begin
				side_n.eq = eq_s2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_n;
		rre_s3  <= nre_w;
		rim_s3  <= nim_w;
		den_s3  <= den_s2;
	end

	// Divider stages: stage k decides quotient bit QW-1-k for both lanes.
	logic                   v_s4   [NSTG+1];
	side_t                  side_s4[NSTG+1];
	logic [RW-1:0]          rre_s4 [NSTG+1];
	logic [RW-1:0]          rim_s4 [NSTG+1];
	logic [QW-1:0]          qre_s4 [NSTG+1];
	logic [QW-1:0]          qim_s4 [NSTG+1];
	logic [PW-1:0]          den_s4 [NSTG+1];

	assign v_s4[0]    = v_s3;
	assign side_s4[0] = side_s3;
	assign rre_s4[0]  = rre_s3;
	assign rim_s4[0]  = rim_s3;
	assign qre_s4[0]  = '0;
	assign qim_s4[0]  = '0;
	assign den_s4[0]  = den_s3;

	for (genvar k = 0; k < NSTG; k++) begin : g_div
		localparam int BIT = QW - 1 - k;
		logic [RW-1:0] trial;
		logic          take_re, take_im;

		assign trial   = RW'(den_s4[k]) << BIT;
		assign take_re = rre_s4[k] >= trial;
		assign take_im = rim_s4[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s4[k+1] <= 1'b0;
			end else begin
				v_s4[k+1] <= v_s4[k];
			end
		end

		// Bit BIT of the incoming quotient is still clear, so it is simply OR-ed in.
		always_ff @(posedge clk) begin
			side_s4[k+1] <= side_s4[k];
			den_s4[k+1]  <= den_s4[k];
			rre_s4[k+1]  <= take_re ? rre_s4[k] - trial : rre_s4[k];
			rim_s4[k+1]  <= take_im ? rim_s4[k] - trial : rim_s4[k];
			qre_s4[k+1]  <= qre_s4[k] | (QW'(take_re) << BIT);
			qim_s4[k+1]  <= qim_s4[k] | (QW'(take_im) << BIT);
		end
	end

	// Output stage: sign and saturate the quotients, pick the result, form the status.
	side_t                  sf;
	logic [QW-1:0]          qr, qi;
	logic                   sat_qr, sat_qi, sat_all;
	logic signed [DW-1:0]   fr, fi;
	logic [1:0]             st_n;
	logic [QW-1:0]          qneg_lim;

	always_comb begin
		sf       = side_s4[NSTG];
		qr       = qre_s4[NSTG];
		qi       = qim_s4[NSTG];
		qneg_lim = {1'b1, {(QW-1){1'b0}}};
		sat_qr   = sf.ovf_re | (sf.neg_re ? (qr > qneg_lim) : qr[QW-1]);
		sat_qi   = sf.ovf_im | (sf.neg_im ? (qi > qneg_lim) : qi[QW-1]);
		fr       = sf.re;
		fi       = sf.im;
		sat_all  = sf.sat;
		if (sf.fn == FN_DIV) begin
			if (sf.dz) begin
				fr      = '0;
				fi      = '0;
				sat_all = 1'b0;
			end else begin
				fr      = sat_qr ? (sf.neg_re ? DMIN : DMAX)
				                 : (sf.neg_re ? DW'(-qr) : DW'(qr));
				fi      = sat_qi ? (sf.neg_im ? DMIN : DMAX)
				                 : (sf.neg_im ? DW'(-qi) : DW'(qi));
				sat_all = sat_qr | sat_qi;
			end
		end
		priority if (sf.fn == FN_DIV && sf.dz) begin
			st_n = ST_DZ;
		end else if (sat_all) begin
			st_n = ST_SAT;
		end else begin
			st_n = ST_OK;
		end
	end

	logic                   done_q;
	logic signed [DW-1:0]   res_re_q, res_im_q;
	logic                   is_equal_q;
	logic [1:0]             status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s4[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		res_re_q   <= fr;
		res_im_q   <= fi;
		is_equal_q <= sf.eq;
		status_q   <= st_n;
	end

	assign done     = done_q;
	assign res_re   = res_re_q;
	assign res_im   = res_im_q;
	assign is_equal = is_equal_q;
	assign status   = status_q;

`ifndef ASSERT_OFF
	// A divide-by-zero beat carries a zero result.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_DZ |-> res_re == '0 && res_im == '0 && !is_equal)
		else $error("divide by zero result not cleared");

	// An equal flag only comes from a compare, which never saturates.
	a_eq_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_equal |-> status == ST_OK && res_re == '0 && res_im == '0)
		else $error("compare beat carries data or status");

	// Every accepted beat later shows up on done.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(NSTG+4) done)
		else $error("result beat missing");

	// The unit never pushes back on the command side.
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("busy raised");
`endif

endmodule
